@@ rtl/ecat_pkg.sv @@
// Package for the datagram framer: shared constants, request/result codes, ctrl/datapath structs.
// No dependencies.
`timescale 1ns / 1ps
package ecat_pkg;
  localparam int unsigned FrameBytesMax = 1500;
  localparam int unsigned MinFrame      = 46;
  localparam int unsigned HdrBytes      = 12;

  localparam logic [1:0] REQ_START = 2'd0;
  localparam logic [1:0] REQ_TX    = 2'd1;
  localparam logic [1:0] REQ_RX    = 2'd2;

  localparam logic [1:0] KIND_TX_BYTE  = 2'd0;
  localparam logic [1:0] KIND_RX_BYTE  = 2'd1;
  localparam logic [1:0] KIND_TX_STAT  = 2'd2;
  localparam logic [1:0] KIND_RX_STAT  = 2'd3;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_SHORT    = 3'd1;
  localparam logic [2:0] ST_LEN      = 3'd2;
  localparam logic [2:0] ST_INCOMPL  = 3'd3;
  localparam logic [2:0] ST_ANOMALY  = 3'd4;
  localparam logic [2:0] ST_TOO_LONG = 3'd5;

  localparam logic [1:0] PH_READY    = 2'd0;
  localparam logic [1:0] PH_SENT     = 2'd1;
  localparam logic [1:0] PH_RECEIVED = 2'd2;

  // controller -> datapath
  typedef struct packed {
    logic load;       // capture input request
    logic start_ok;   // commit start command
    logic too_long;   // reject start
    logic tx_byte;    // consume payload byte
    logic rx_byte;    // parse received byte
    logic emit;       // push one result into output register
    logic [1:0] kind;
    logic [5:0] pos;  // header/tail byte position
    logic sel_hdr;    // emit header byte at pos
    logic sel_pay;    // emit payload byte
    logic sel_tail;   // emit zero tail byte
    logic tail_end;
    logic sel_rx;     // emit received payload byte
    logic sel_rxst;   // emit receive status
    logic last;
  } ecat_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic [1:0]  req;
    logic        len_too_long;
    logic        len_zero;
    logic        tx_rem_zero;
    logic        tx_rem_one;
    logic [5:0]  tail_first;  // first tail position
    logic [5:0]  tail_end;    // last tail position
    logic        rx_stream;   // received byte is a matched payload byte
    logic        rx_last;
    logic        out_busy;
  } ecat_sts_t;
endpackage

@@ rtl/ecat_ctrl.sv @@
// Controller FSM of the datagram framer: sequences header, payload, tail and status results.
// Depends on ecat_pkg.
`timescale 1ns / 1ps
module ecat_ctrl import ecat_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  ecat_sts_t sts_i,
  output ecat_cmd_t cmd_o
);
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DEC  = 3'd1;
  localparam logic [2:0] S_HDR  = 3'd2;
  localparam logic [2:0] S_TAIL = 3'd3;
  localparam logic [2:0] S_RXST = 3'd4;

  logic [2:0] state_q, state_d;
  logic [5:0] pos_q, pos_d;
  logic [5:0] tend_q, tend_d;
  logic       hold;

  assign in_stall_o = (state_q != S_IDLE);
  assign hold = sts_i.out_busy;

  always_comb begin
    state_d = state_q;
    pos_d   = pos_q;
    tend_d  = tend_q;
    cmd_o   = '0;
    cmd_o.pos = pos_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d = S_DEC;
        end
      end
      S_DEC: begin
        if (!hold) begin
          case (sts_i.req)
            REQ_START: begin
              if (sts_i.len_too_long) begin
                cmd_o.too_long = 1'b1;
                cmd_o.emit = 1'b1;
                cmd_o.kind = KIND_TX_STAT;
                cmd_o.last = 1'b1;
                state_d = S_IDLE;
              end else begin
                cmd_o.start_ok = 1'b1;
                pos_d = 6'd0;
                state_d = S_HDR;
              end
            end
            REQ_TX: begin
              if (sts_i.tx_rem_zero) begin
                state_d = S_IDLE;
              end else begin
                cmd_o.tx_byte = 1'b1;
                cmd_o.emit = 1'b1;
                cmd_o.sel_pay = 1'b1;
                cmd_o.kind = KIND_TX_BYTE;
                if (sts_i.tx_rem_one) begin
                  pos_d  = sts_i.tail_first;
                  tend_d = sts_i.tail_end;
                  state_d = S_TAIL;
                end else begin
                  cmd_o.last = 1'b1;
                  state_d = S_IDLE;
                end
              end
            end
            REQ_RX: begin
              cmd_o.rx_byte = 1'b1;
              if (sts_i.rx_stream) begin
                cmd_o.emit = 1'b1;
                cmd_o.sel_rx = 1'b1;
                cmd_o.kind = KIND_RX_BYTE;
                cmd_o.last = !sts_i.rx_last;
              end
              state_d = sts_i.rx_last ? S_RXST : S_IDLE;
            end
            default: state_d = S_IDLE;
          endcase
        end
      end
      S_HDR: begin
        if (!hold) begin
          cmd_o.emit = 1'b1;
          cmd_o.sel_hdr = 1'b1;
          cmd_o.kind = KIND_TX_BYTE;
          pos_d = pos_q + 6'd1;
          if (pos_q == 6'(HdrBytes - 1)) begin
            if (sts_i.len_zero) begin
              pos_d  = 6'(HdrBytes);
              tend_d = 6'(MinFrame - 1);
              state_d = S_TAIL;
            end else begin
              cmd_o.last = 1'b1;
              state_d = S_IDLE;
            end
          end
        end
      end
      S_TAIL: begin
        if (!hold) begin
          cmd_o.emit = 1'b1;
          cmd_o.sel_tail = 1'b1;
          cmd_o.kind = KIND_TX_BYTE;
          pos_d = pos_q + 6'd1;
          if (pos_q == tend_q) begin
            cmd_o.tail_end = 1'b1;
            cmd_o.last = 1'b1;
            state_d = S_IDLE;
          end
        end
      end
      S_RXST: begin
        if (!hold) begin
          cmd_o.emit = 1'b1;
          cmd_o.sel_rxst = 1'b1;
          cmd_o.kind = KIND_RX_STAT;
          cmd_o.last = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      pos_q   <= '0;
      tend_q  <= '0;
    end else begin
      state_q <= state_d;
      pos_q   <= pos_d;
      tend_q  <= tend_d;
    end
  end
endmodule

@@ rtl/ecat_dp.sv @@
// Datapath of the datagram framer: command state, receive parser, result register.
// Depends on ecat_pkg.
`timescale 1ns / 1ps
module ecat_dp import ecat_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [1:0]  req_type_i,
  input  logic [7:0]  cmd_type_i,
  input  logic [31:0] slave_address_i,
  input  logic [10:0] payload_length_i,
  input  logic [7:0]  data_byte_i,
  input  logic        frame_last_i,
  input  ecat_cmd_t   cmd_i,
  output ecat_sts_t   sts_o,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  kind_o,
  output logic [7:0]  byte_value_o,
  output logic        frame_end_o,
  output logic [2:0]  status_o,
  output logic [15:0] working_counter_o,
  output logic        run_last_o
);
  // captured request
  logic [1:0]  req_q;
  logic [7:0]  ctype_q, byte_q;
  logic [31:0] addr_q;
  logic [10:0] len_q;
  logic        flast_q;

  // command state
  logic [7:0]  next_index_q, p_type_q, p_index_q;
  logic [10:0] p_len_q, tx_rem_q;
  logic [1:0]  phase_q;
  logic        p_write_q;

  // receive state
  logic [11:0] rx_count_q;
  logic [10:0] rx_flen_q;
  logic [31:0] rx_hdr_q;
  logic [15:0] rx_wc_q;
  logic        rx_match_q;
  logic [2:0]  rx_st_q;
  logic [15:0] rx_wcout_q;

  // output register
  logic        ovalid_q, ofe_q, olast_q;
  logic [1:0]  okind_q;
  logic [7:0]  obyte_q;
  logic [2:0]  ost_q;
  logic [15:0] owc_q;

  logic [10:0] dl_cur;
  logic [12:0] dl12, p_ext;
  logic [11:0] glen;
  logic [12:0] tail_pos;
  logic [7:0]  hdr_byte, out_byte;
  logic        is_wr;

  // receive parser
  logic [31:0] hdr_d;
  logic [10:0] dl_d;
  logic        match_d;
  logic [15:0] wc_d;
  logic [10:0] flen_d;
  logic [12:0] n_ext;
  logic [2:0]  st_d;

  assign dl_cur = {rx_hdr_q[26:24], rx_hdr_q[23:16]};
  assign dl12   = 13'(dl_cur) + 13'd12;
  assign p_ext  = {1'b0, rx_count_q};
  assign glen   = 12'(len_q) + 12'd12;
  assign is_wr  = (ctype_q == 8'h02) || (ctype_q == 8'h05) ||
                  (ctype_q == 8'h08) || (ctype_q == 8'h0C);
  // tail starts right after the payload; only a short payload leaves room for padding
  assign tail_pos = 13'(p_len_q) + 13'(HdrBytes);

  assign sts_o.req          = req_q;
  assign sts_o.len_too_long = (12'(len_q) + 12'd14) > 12'(FrameBytesMax);
  assign sts_o.len_zero     = (p_len_q == '0);
  assign sts_o.tx_rem_zero  = (tx_rem_q == '0);
  assign sts_o.tx_rem_one   = (tx_rem_q == 11'd1);
  assign sts_o.tail_first   = (tail_pos < 13'(MinFrame - 2)) ? tail_pos[5:0] : 6'd0;
  assign sts_o.tail_end     = (tail_pos < 13'(MinFrame - 2)) ? 6'(MinFrame - 1) : 6'd1;
  assign sts_o.rx_stream    = (rx_count_q >= 12'd12) && (p_ext < dl12) && rx_match_q;
  assign sts_o.rx_last      = flast_q;
  assign sts_o.out_busy     = ovalid_q && out_stall_i;

  always_comb begin
    case (cmd_i.pos[3:0])
      4'd0:    hdr_byte = glen[7:0];
      4'd1:    hdr_byte = {5'b00010, glen[10:8]};
      4'd2:    hdr_byte = p_type_q;
      4'd3:    hdr_byte = p_index_q;
      4'd4:    hdr_byte = addr_q[7:0];
      4'd5:    hdr_byte = addr_q[15:8];
      4'd6:    hdr_byte = addr_q[23:16];
      4'd7:    hdr_byte = addr_q[31:24];
      4'd8:    hdr_byte = p_len_q[7:0];
      4'd9:    hdr_byte = {5'b0, p_len_q[10:8]};
      default: hdr_byte = 8'h00;
    endcase
    out_byte = 8'h00;
    if (cmd_i.sel_hdr) out_byte = hdr_byte;
    if (cmd_i.sel_pay) out_byte = p_write_q ? byte_q : 8'h00;
    if (cmd_i.sel_rx)  out_byte = byte_q;
  end

  // request capture and result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q   <= req_type_i;
      ctype_q <= cmd_type_i;
      addr_q  <= slave_address_i;
      len_q   <= payload_length_i;
      byte_q  <= data_byte_i;
      flast_q <= frame_last_i;
    end
    if (cmd_i.emit) begin
      okind_q <= cmd_i.kind;
      obyte_q <= out_byte;
      ofe_q   <= cmd_i.tail_end;
      olast_q <= cmd_i.last;
      ost_q   <= cmd_i.too_long ? ST_TOO_LONG : (cmd_i.sel_rxst ? rx_st_q : ST_OK);
      owc_q   <= cmd_i.sel_rxst ? rx_wcout_q : 16'h0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovalid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      ovalid_q <= 1'b1;
    end else if (!out_stall_i) begin
      ovalid_q <= 1'b0;
    end
  end

  // command state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      next_index_q <= '0;
      p_type_q     <= '0;
      p_index_q    <= '0;
      p_len_q      <= '0;
      tx_rem_q     <= '0;
      phase_q      <= PH_READY;
      p_write_q    <= 1'b0;
    end else begin
      if (cmd_i.too_long) begin
        phase_q  <= PH_READY;
        tx_rem_q <= '0;
      end
      if (cmd_i.start_ok) begin
        p_index_q    <= next_index_q;
        next_index_q <= next_index_q + 8'd1;
        p_type_q     <= ctype_q;
        p_len_q      <= len_q;
        p_write_q    <= is_wr;
        phase_q      <= PH_SENT;
        tx_rem_q     <= len_q;
      end
      if (cmd_i.tx_byte) tx_rem_q <= tx_rem_q - 11'd1;
      if (cmd_i.rx_byte && flast_q && (st_d == ST_OK)) phase_q <= PH_RECEIVED;
    end
  end

  always_comb begin
    hdr_d   = rx_hdr_q;
    match_d = rx_match_q;
    wc_d    = rx_wc_q;
    flen_d  = rx_flen_q;
    dl_d    = dl_cur;
    case (rx_count_q)
      12'd0: begin
        hdr_d   = {24'h0, byte_q};
        match_d = 1'b0;
        wc_d    = '0;
        flen_d  = '0;
        dl_d    = '0;
      end
      12'd1: begin
        flen_d = {byte_q[2:0], rx_hdr_q[7:0]};
        hdr_d  = '0;
        dl_d   = '0;
      end
      12'd2: hdr_d[7:0]   = byte_q;
      12'd3: hdr_d[15:8]  = byte_q;
      12'd8: hdr_d[23:16] = byte_q;
      12'd9: begin
        hdr_d[31:24] = byte_q;
        dl_d    = {byte_q[2:0], rx_hdr_q[23:16]};
        match_d = (phase_q == PH_SENT) && (rx_hdr_q[7:0] == p_type_q) &&
                  (rx_hdr_q[15:8] == p_index_q) && (dl_d == p_len_q);
      end
      default: begin
        if (rx_count_q >= 12'd12) begin
          if (p_ext == dl12) wc_d[7:0] = byte_q;
          else if (p_ext == dl12 + 13'd1) wc_d[15:8] = byte_q;
        end
      end
    endcase
    n_ext = p_ext + 13'd1;
    if (n_ext < 13'd2)                  st_d = ST_SHORT;
    else if (13'(flen_d) > n_ext)       st_d = ST_LEN;
    else if (n_ext - 13'd2 < 13'(dl_d) + 13'd12) st_d = ST_INCOMPL;
    else if (!match_d)                  st_d = ST_ANOMALY;
    else                                st_d = ST_OK;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rx_count_q <= '0;
      rx_flen_q  <= '0;
      rx_hdr_q   <= '0;
      rx_wc_q    <= '0;
      rx_match_q <= 1'b0;
      rx_st_q    <= ST_OK;
      rx_wcout_q <= '0;
    end else if (cmd_i.rx_byte) begin
      rx_hdr_q  <= hdr_d;
      rx_flen_q <= flen_d;
      rx_wc_q   <= wc_d;
      if (flast_q) begin
        rx_count_q <= '0;
        rx_match_q <= 1'b0;
        rx_st_q    <= st_d;
        rx_wcout_q <= (st_d == ST_OK) ? wc_d : 16'h0;
      end else begin
        rx_match_q <= match_d;
        if (rx_count_q != 12'hFFF) rx_count_q <= rx_count_q + 12'd1;
      end
    end
  end

  assign out_valid_o       = ovalid_q;
  assign kind_o            = okind_q;
  assign byte_value_o      = obyte_q;
  assign frame_end_o       = ofe_q;
  assign status_o          = ost_q;
  assign working_counter_o = owc_q;
  assign run_last_o        = olast_q;
endmodule

@@ rtl/ethercat_datagram_framer.sv @@
// Top level of the single-datagram frame builder and checker.
// Depends on ecat_pkg, ecat_ctrl, ecat_dp.
`timescale 1ns / 1ps
// One request is taken at a time. A start request emits one result per header byte and, for
// an empty payload, per tail byte (12 header bytes, and 34 tail bytes); a payload request
// emits one byte if any remain, and the tail after the final payload byte; a received byte
// emits a matched payload byte and, on the last byte of a frame, the receive status. Every
// result passes one output register, which the controller waits on while it is stalled.
module ethercat_datagram_framer import ecat_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  req_type_i,
  input  logic [7:0]  cmd_type_i,
  input  logic [31:0] slave_address_i,
  input  logic [10:0] payload_length_i,
  input  logic [7:0]  data_byte_i,
  input  logic        frame_last_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  kind_o,
  output logic [7:0]  byte_value_o,
  output logic        frame_end_o,
  output logic [2:0]  status_o,
  output logic [15:0] working_counter_o,
  output logic        run_last_o
);
  ecat_cmd_t cmd;
  ecat_sts_t sts;

  ecat_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o,
    .sts_i(sts), .cmd_o(cmd)
  );

  ecat_dp u_dp (
    .clk_i, .rst_ni, .req_type_i, .cmd_type_i, .slave_address_i, .payload_length_i,
    .data_byte_i, .frame_last_i, .cmd_i(cmd), .sts_o(sts), .out_valid_o, .out_stall_i,
    .kind_o, .byte_value_o, .frame_end_o, .status_o, .working_counter_o, .run_last_o
  );
endmodule
